### rtl/tcw_pkg.sv
package tcw_pkg;

	// Fixed field widths of the command and response words
	localparam int unsigned COL_FIELD_W  = 7;
	localparam int unsigned LINE_FIELD_W = 5;
	localparam int unsigned BYTE_W       = 8;

	// Configuration port
	localparam int unsigned APB_ADDR_W   = 3;
	localparam int unsigned APB_DATA_W   = 32;

	localparam logic [BYTE_W-1:0] NEWLINE_CHAR       = 8'd10;
	localparam logic [BYTE_W-1:0] BLANK_CHAR         = 8'd32;
	localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

	typedef enum logic [0:0] {
		REG_DEFAULT_ATTR = 1'b0
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_SCR_ZERO,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t                    command;
		logic [BYTE_W-1:0]       character;
		logic [BYTE_W-1:0]       attribute;
		logic                    use_cursor;
		logic [COL_FIELD_W-1:0]  column;
		logic [LINE_FIELD_W-1:0] line;
	} cmd_word_t;

	typedef struct packed {
		logic [COL_FIELD_W-1:0]  cursor_column;
		logic [LINE_FIELD_W-1:0] cursor_line;
		logic                    scrolled;
		logic [BYTE_W-1:0]       read_character;
		logic [BYTE_W-1:0]       read_attribute;
	} rsp_word_t;

endpackage

### rtl/tcw_apb_regs.sv
module tcw_apb_regs
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [BYTE_W-1:0]     default_attr
);

	reg_index_t       reg_index;
	logic             wr_en;
	logic [BYTE_W-1:0] default_attr_q;

	assign pready    = 1'b1;
	assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1]);
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEFAULT_ATTR_RESET;
		end else if (wr_en && reg_index == REG_DEFAULT_ATTR) begin
			default_attr_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_index)
			REG_DEFAULT_ATTR: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, default_attr_q};
			default:          prdata = '0;
		endcase
	end

	assign default_attr = default_attr_q;

endmodule

### rtl/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS grid of cells (attribute byte over character byte)
// in a memory with one write and one read port, plus a cursor held as column and row.
// Commands arrive as one word on cmd_valid/cmd_stall and each returns one word on
// rsp_valid/rsp_stall. For a put, read or no-op the cell is written or read at the accept
// edge and the response is loaded in the finishing state once the response slot is free.
// A clear walks every cell once. A put that runs past the last cell scrolls the grid: each
// of the COLUMNS*(ROWS-1) moved cells takes a read and then a write, and then the bottom
// row is zeroed. After reset the grid is cleared to zero by a pass over every cell during
// which no command is taken; configuration writes are accepted throughout. cmd_stall is
// high whenever a command is in progress; the response register lets the next command
// start while the last response still waits to be taken.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_word_t             cmd_word,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_word_t             rsp_word,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int NCELLS = COLUMNS * ROWS;
	localparam int CW     = $clog2(COLUMNS);
	localparam int RW     = $clog2(ROWS);
	localparam int AW     = $clog2(NCELLS);

	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
	localparam logic [AW-1:0] LAST_MOVE = AW'(NCELLS - COLUMNS - 1);

	// Configuration register
	logic [BYTE_W-1:0] default_attr;

	tcw_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.default_attr (default_attr)
	);

	state_t            state_q, state_d;
	logic [AW-1:0]     addr_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     line_q;
	logic              scrolled_q;
	logic              rd_hit_q;
	logic              rsp_valid_q;
	rsp_word_t         rsp_word_q;
	logic [15:0]       rdata_q;
	logic [15:0]       cell_mem [NCELLS];

	logic              accept;
	logic              out_free;
	logic              in_range;
	logic              is_put, is_read, is_clear;
	logic              at_cursor;
	logic              put_act, put_nl, wrap, ovf;
	logic [CW-1:0]     tcol, nxt_col;
	logic [RW-1:0]     tline, nxt_line;
	logic [AW-1:0]     pos_addr;
	logic [BYTE_W-1:0] attr_eff;

	logic              we, re, step, rsp_load;
	logic [AW-1:0]     waddr, raddr;
	logic [15:0]       wdata;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Decode the command word and work out the target cell and the cursor that follows
	assign is_put    = (cmd_word.command == CMD_PUT);
	assign is_read   = (cmd_word.command == CMD_READ);
	assign is_clear  = (cmd_word.command == CMD_CLEAR);
	assign in_range  = ({1'b0, cmd_word.column} < 8'(COLUMNS))
	                && ({2'b00, cmd_word.line} < 7'(ROWS));
	assign at_cursor = is_put && cmd_word.use_cursor;
	assign put_act   = is_put && (cmd_word.use_cursor || in_range);
	assign put_nl    = (cmd_word.character == NEWLINE_CHAR);

	assign tcol  = at_cursor ? col_q  : CW'(cmd_word.column);
	assign tline = at_cursor ? line_q : RW'(cmd_word.line);

	assign pos_addr = AW'(tline) * AW'(COLUMNS) + AW'(tcol);
	assign attr_eff = (cmd_word.attribute == '0) ? default_attr : cmd_word.attribute;

	// A newline behaves as a put in the last column with nothing written
	assign wrap     = put_nl || (tcol == LAST_COL);
	assign ovf      = wrap && (tline == LAST_ROW);
	assign nxt_col  = wrap ? '0 : CW'(tcol + CW'(1));
	assign nxt_line = !wrap ? tline : (ovf ? LAST_ROW : RW'(tline + RW'(1)));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (addr_q == LAST_CELL) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_word.command) inside
						CMD_PUT:            state_d = (put_act && ovf) ? ST_SCR_RD : ST_FINISH;
						CMD_CLEAR:          state_d = ST_CLEAR;
						CMD_READ, CMD_NOP:  state_d = ST_FINISH;
						default:            state_d = ST_FINISH;
					endcase
				end
			end
			ST_SCR_RD:   state_d = ST_SCR_WR;
			ST_SCR_WR: begin
				state_d = (addr_q == LAST_MOVE) ? ST_SCR_ZERO : ST_SCR_RD;
			end
			ST_SCR_ZERO: begin
				if (addr_q == LAST_CELL) state_d = ST_FINISH;
			end
			ST_CLEAR: begin
				if (addr_q == LAST_CELL) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_INIT;
		endcase
	end

	// Memory port and sweep control
	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		step     = 1'b0;
		rsp_load = 1'b0;
		waddr    = addr_q;
		raddr    = pos_addr;
		wdata    = '0;
		unique case (state_q)
			ST_INIT: begin
				we   = 1'b1;
				step = 1'b1;
			end
			ST_IDLE: begin
				we    = accept && put_act && !put_nl;
				waddr = pos_addr;
				wdata = {attr_eff, cmd_word.character};
				re    = accept && is_read && in_range;
			end
			ST_SCR_RD: begin
				re    = 1'b1;
				raddr = AW'(addr_q + AW'(COLUMNS));
			end
			ST_SCR_WR: begin
				we    = 1'b1;
				wdata = rdata_q;
				step  = 1'b1;
			end
			ST_SCR_ZERO: begin
				we   = 1'b1;
				step = 1'b1;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = {default_attr, BLANK_CHAR};
				step  = 1'b1;
			end
			ST_FINISH: begin
				rsp_load = out_free;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			col_q       <= '0;
			line_q      <= '0;
			scrolled_q  <= 1'b0;
			rd_hit_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// restart the sweep for whatever walk this command needs
				addr_q     <= '0;
				scrolled_q <= put_act && ovf;
				rd_hit_q   <= is_read && in_range;
				if (put_act) begin
					col_q  <= nxt_col;
					line_q <= nxt_line;
				end else if (is_clear) begin
					col_q  <= '0;
					line_q <= '0;
				end
			end else if (step) begin
				addr_q <= AW'(addr_q + AW'(1));
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response word: hold while stalled, load only when the slot is free
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_word_q.cursor_column  <= COL_FIELD_W'(col_q);
			rsp_word_q.cursor_line    <= LINE_FIELD_W'(line_q);
			rsp_word_q.scrolled       <= scrolled_q;
			rsp_word_q.read_character <= rd_hit_q ? rdata_q[7:0]  : '0;
			rsp_word_q.read_attribute <= rd_hit_q ? rdata_q[15:8] : '0;
		end
	end

	// Cell memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= cell_mem[raddr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// A response appears only on leaving the finishing step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside the finishing step");

	// The cursor never leaves the grid
	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= LAST_COL) && (line_q <= LAST_ROW))
		else $error("cursor outside the grid");

	// A scrolled response leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_word_q.scrolled |->
			(rsp_word_q.cursor_column == '0) &&
			(rsp_word_q.cursor_line == LINE_FIELD_W'(LAST_ROW)))
		else $error("scroll left the cursor off the bottom row start");

	// Every write and read lands inside the grid
	a_mem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!we || (waddr <= LAST_CELL)) && (!re || (raddr <= LAST_CELL)))
		else $error("cell memory accessed out of range");

endmodule
